// File: hdl/rfr_pkg.sv
`default_nettype none

package rfr_pkg;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 24;
    localparam int TMO_W   = 16;
    localparam int DUR_W   = 17;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // event codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLR_AVAIL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLR_DET   = 2'd3;

    // mode codes shown on the result
    localparam logic [MODE_W-1:0] MODE_CODE_WAIT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_TIMING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_REENTRY = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // register reset values
    localparam logic [BYTE_W-1:0] START_RST   = 8'd2;
    localparam logic [BYTE_W-1:0] END_RST     = 8'd3;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd1000;

    // frame byte positions and index limit
    localparam int                NUM_DATA  = 3;
    localparam logic [IDX_W-1:0]  IDX_FIRST = 3'd1;
    localparam logic [IDX_W-1:0]  IDX_LAST  = 3'd3;
    localparam logic [IDX_W-1:0]  IDX_MAX   = 3'd7;

    localparam logic [DUR_W-1:0]  DUR_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] rx_byte;
        logic              valid_pin;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] code_value;
        logic              code_detected;
        logic              code_available;
        logic [DUR_W-1:0]  press_duration_ms;
        logic [MODE_W-1:0] mode;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [TMO_W-1:0]  timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_frame;

endpackage

`default_nettype wire

// File: hdl/rfr_in_if.sv
`default_nettype none

interface rfr_in_if;
    import rfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;
    logic              valid_pin;

    modport source (output valid, output func, output rx_byte, output valid_pin, input ready);
    modport sink   (input valid, input func, input rx_byte, input valid_pin, output ready);
endinterface

`default_nettype wire

// File: hdl/rfr_out_if.sv
`default_nettype none

interface rfr_out_if;
    import rfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_value;
    logic              code_detected;
    logic              code_available;
    logic [DUR_W-1:0]  press_duration_ms;
    logic [MODE_W-1:0] mode;

    modport source (output valid, output code_value, output code_detected,
                    output code_available, output press_duration_ms, output mode,
                    input ready);
    modport sink   (input valid, input code_value, input code_detected,
                    input code_available, input press_duration_ms, input mode,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/rfr_framer.sv
`default_nettype none

module rfr_framer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_take,
    input  wire logic [7:0]            i_byte,
    input  wire rfr_pkg::t_cfg         i_cfg,
    output rfr_pkg::t_frame            o_frame
);
    import rfr_pkg::*;

    logic              r_in_frame;
    logic [IDX_W-1:0]  r_byte_index;
    logic [BYTE_W-1:0] r_bytes [NUM_DATA];

    logic              opens;
    logic              active;
    logic              is_end;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] packed_code;
    logic [1:0]        wr_pos;

    // frame open/close decode
    assign opens  = !r_in_frame && (i_byte == i_cfg.start_byte);
    assign active = r_in_frame || opens;
    assign is_end = (i_byte == i_cfg.end_byte);
    assign idx    = opens ? '0 : r_byte_index;
    assign wr_pos = 2'(idx - IDX_FIRST);

    assign packed_code = {r_bytes[0], r_bytes[1], r_bytes[2]};

    // a closing byte inside a frame yields the packed data bytes when they are nonzero
    assign o_frame.hit  = i_take && active && is_end && (packed_code != '0);
    assign o_frame.code = packed_code;

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_index <= '0;
            for (int k = 0; k < NUM_DATA; k++) begin
                r_bytes[k] <= '0;
            end
        end else if (i_step && i_take && active) begin
            if (is_end) begin
                r_in_frame   <= 1'b0;
                r_byte_index <= '0;
            end else begin
                r_in_frame <= 1'b1;
                if (idx >= IDX_FIRST && idx <= IDX_LAST) begin
                    r_bytes[wr_pos] <= i_byte;
                end
                r_byte_index <= (idx < IDX_MAX) ? idx + 3'd1 : idx;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/rfr_core.sv
`default_nettype none

module rfr_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire rfr_pkg::t_item    i_item,
    input  wire rfr_pkg::t_cfg     i_cfg,
    output rfr_pkg::t_result       o_next
);
    import rfr_pkg::*;

    localparam int CW = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
    localparam int TW = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT    = 2'd0,
        MODE_TIMING  = 2'd1,
        MODE_REENTRY = 2'd2
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [CODE_W-1:0]     r_code, n_code;
    logic                  r_det, n_det;
    logic                  r_av, n_av;
    logic [TIMER_BITS-1:0] r_cnt, n_cnt;
    logic [DUR_W-1:0]      r_dur, n_dur;

    logic   take;
    t_frame frame;
    logic [CW-1:0] cnt_dur;
    logic [TW-1:0] cnt_cmp;

    // bytes are framed only while waiting for a code
    assign take = (r_mode != MODE_TIMING) && (r_mode != MODE_REENTRY)
                  && (i_item.func == FUNC_BYTE);

    rfr_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (i_step),
        .i_take  (take),
        .i_byte  (i_item.rx_byte),
        .i_cfg   (i_cfg),
        .o_frame (frame)
    );

    // next state of the receiver
    always_comb begin
        n_mode  = r_mode;
        n_code  = r_code;
        n_det   = r_det;
        n_av    = r_av;
        n_cnt   = r_cnt;
        n_dur   = r_dur;
        cnt_dur = '0;
        cnt_cmp = '0;

        if (i_item.func == FUNC_TICK && r_cnt != '1) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (i_item.func == FUNC_CLR_AVAIL) begin
            n_av = 1'b0;
        end
        if (i_item.func == FUNC_CLR_DET) begin
            n_det = 1'b0;
        end

        cnt_dur = CW'(n_cnt);
        cnt_cmp = TW'(n_cnt);

        unique case (r_mode)
            MODE_TIMING: begin
                if (i_item.valid_pin) begin
                    if (!n_av) begin
                        n_av  = 1'b1;
                        n_dur = (cnt_dur > CW'(DUR_MAX)) ? DUR_MAX : cnt_dur[DUR_W-1:0];
                    end
                    n_mode = MODE_WAIT;
                end else if (cnt_cmp > TW'(i_cfg.timeout_ms)) begin
                    n_av   = 1'b1;
                    n_dur  = {i_cfg.timeout_ms, 1'b0};
                    n_mode = MODE_REENTRY;
                end
            end
            MODE_REENTRY: begin
                if (i_item.valid_pin) begin
                    n_dur  = '0;
                    n_mode = MODE_WAIT;
                end
            end
            default: begin
                n_mode = MODE_WAIT;
                if (frame.hit) begin
                    n_code = frame.code;
                    n_det  = 1'b1;
                    n_cnt  = '0;
                    n_mode = MODE_TIMING;
                end
            end
        endcase
    end

    assign o_next.code_value        = n_code;
    assign o_next.code_detected     = n_det;
    assign o_next.code_available    = n_av;
    assign o_next.press_duration_ms = n_dur;
    assign o_next.mode              = n_mode;

    // state update, one item per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_code <= '0;
            r_det  <= 1'b0;
            r_av   <= 1'b0;
            r_cnt  <= '0;
            r_dur  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_code <= n_code;
            r_det  <= n_det;
            r_av   <= n_av;
            r_cnt  <= n_cnt;
            r_dur  <= n_dur;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rf_code_frame_receiver_top.sv
// channel   dir  handshake        payload
// i_req     in   valid / ready    func[1:0], rx_byte[7:0], valid_pin
// o_res     out  valid / ready    code_value[23:0], code_detected, code_available,
//                                 press_duration_ms[16:0], mode[1:0]
// cfg       in   i_cfg_wr_en      i_cfg_index[1:0], i_cfg_data[15:0]
//
// one request per cycle sustained while o_res is not stalled; a result reaches o_res
// through the input register, then the result register
// the update of the receiver state is a single pass from the input register
// i_rst_n is synchronous; control registers clear and configuration registers take their reset values
// a stalled result holds in the result register; the input register takes a request
// when it is empty or when its item moves on in the same cycle
`default_nettype none

module rf_code_frame_receiver_top #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    rfr_in_if.sink                                  i_req,
    rfr_out_if.source                               o_res,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [rfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rfr_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    t_result next_res;
    logic    advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= START_RST;
            r_cfg.end_byte   <= END_RST;
            r_cfg.timeout_ms <= TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START:   r_cfg.start_byte <= i_cfg_data[BYTE_W-1:0];
                CFG_END:     r_cfg.end_byte   <= i_cfg_data[BYTE_W-1:0];
                CFG_TIMEOUT: r_cfg.timeout_ms <= i_cfg_data[TMO_W-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // pipeline flow
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.func      <= i_req.func;
            r_in.rx_byte   <= i_req.rx_byte;
            r_in.valid_pin <= i_req.valid_pin;
        end
    end

    rfr_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_next  (next_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_res;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.code_value        = r_out.code_value;
    assign o_res.code_detected     = r_out.code_detected;
    assign o_res.code_available    = r_out.code_available;
    assign o_res.press_duration_ms = r_out.press_duration_ms;
    assign o_res.mode              = r_out.mode;

endmodule

`default_nettype wire

// File: hdl/rfr_checker.sv
`default_nettype none

module rfr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_code_value,
    input  wire logic [16:0] i_press_duration_ms,
    input  wire logic [1:0]  i_mode
);
    import rfr_pkg::*;

    // only the three defined mode codes leave the block
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mode == MODE_CODE_WAIT || i_mode == MODE_CODE_TIMING
                         || i_mode == MODE_CODE_REENTRY))
        else $error("undefined mode code on result");

    // timing or reentry only follow a nonzero code
    a_code_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_mode == MODE_CODE_TIMING || i_mode == MODE_CODE_REENTRY))
            |-> (i_code_value != 24'd0))
        else $error("press mode without a code");

    // reentry always reports twice the timeout, an even duration
    a_reentry_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_mode == MODE_CODE_REENTRY) |-> (i_press_duration_ms[0] == 1'b0))
        else $error("odd duration in reentry protection");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_code_value) && $stable(i_mode)
             && $stable(i_press_duration_ms)))
        else $error("result changed under stall");

endmodule

bind rf_code_frame_receiver_top rfr_checker u_rfr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_code_value        (o_res.code_value),
    .i_press_duration_ms (o_res.press_duration_ms),
    .i_mode              (o_res.mode)
);

`default_nettype wire
